// ===== design/olist_pkg.sv =====
// ----------------------------------------------------------------------------
// olist_pkg: shared types and codes of the ordered list engine
// Operation and status codes, fixed field widths and the command word that
// the sequencer hands to every cell of the list.
// ----------------------------------------------------------------------------
package olist_pkg;

  localparam int OP_W     = 2;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 2;
  localparam int WHERE_W  = 4;
  localparam int LENGTH_W = 5;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;

  // Per-cell command from the sequencer.
  typedef struct packed {
    logic live;       // cell holds a valid entry
    logic take_prev;  // load the entry of the cell toward the head
    logic take_word;  // load the request word
    logic take_next;  // load the entry of the cell toward the tail
  } cell_cmd_t;

endpackage

// ===== design/olist_req_if.sv =====
// ----------------------------------------------------------------------------
// olist_req_if: request channel of the ordered list engine
// Carries one request word: operation, value and insert position.
// ----------------------------------------------------------------------------
interface olist_req_if #(
  parameter int DATA_WIDTH = 32
);
  logic                               valid;
  logic                               ready;
  logic [olist_pkg::OP_W-1:0]         op;
  logic signed [DATA_WIDTH-1:0]       value;
  logic [olist_pkg::POS_W-1:0]        position;

  modport source (output valid, output op, output value, output position, input ready);
  modport sink   (input valid, input op, input value, input position, output ready);
endinterface

// ===== design/olist_rsp_if.sv =====
// ----------------------------------------------------------------------------
// olist_rsp_if: response channel of the ordered list engine
// Carries one response word: status, found flag, position and new length.
// ----------------------------------------------------------------------------
interface olist_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [olist_pkg::STATUS_W-1:0]     status;
  logic                               found;
  logic [olist_pkg::WHERE_W-1:0]      where;
  logic [olist_pkg::LENGTH_W-1:0]     length;

  modport source (output valid, output status, output found, output where, output length,
                  input ready);
  modport sink   (input valid, input status, input found, input where, input length,
                  output ready);
endinterface

// ===== design/olist_cell.sv =====
// ----------------------------------------------------------------------------
// olist_cell: one entry of the list
// Holds a word, compares it with the key and passes the first-match prefix
// and its word on to its neighbors.
// ----------------------------------------------------------------------------
module olist_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                    clk,
  input  olist_pkg::cell_cmd_t    cmd,
  input  logic [DATA_WIDTH-1:0]   key,
  input  logic [DATA_WIDTH-1:0]   prev_data,
  input  logic [DATA_WIDTH-1:0]   next_data,
  input  logic                    seen_in,
  output logic                    seen_out,
  output logic [DATA_WIDTH-1:0]   data
);

  // Once any cell toward the head has matched, every later cell is marked.
  assign seen_out = seen_in | (cmd.live & (data == key));

  always_ff @(posedge clk) begin
    if (cmd.take_word) begin
      data <= key;
    end else if (cmd.take_prev) begin
      data <= prev_data;
    end else if (cmd.take_next) begin
      data <= next_data;
    end
  end

endmodule

// ===== design/olist_ctrl.sv =====
// ----------------------------------------------------------------------------
// olist_ctrl: request sequencer of the ordered list engine
// Latches a request, reads the match marks of the cells, drives the shift
// commands and loads the response register.
// ----------------------------------------------------------------------------
module olist_ctrl #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  olist_req_if.sink               req,
  olist_rsp_if.source             rsp,
  input  logic [DEPTH-1:0]        seen,
  output logic [DATA_WIDTH-1:0]   key,
  output olist_pkg::cell_cmd_t    cmd [DEPTH]
);

  localparam int FW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = (FW > olist_pkg::POS_W) ? FW : olist_pkg::POS_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MATCH = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  logic [1:0]                 state;
  logic [1:0]                 state_next;
  logic [olist_pkg::OP_W-1:0] op;
  logic [olist_pkg::POS_W-1:0] pos;
  logic [FW-1:0]              fill;
  logic [FW-1:0]              fill_next;
  logic [DEPTH-1:0]           mark;
  logic [CW-1:0]              hit_pos;
  logic                       found;
  logic                       full;

  logic                       accept;
  logic                       commit;
  logic                       is_ins;
  logic                       is_find;
  logic [FW-1:0]              pivot;
  logic [DEPTH-1:0]           mark_c;
  logic [DEPTH-1:0]           first;
  logic [DEPTH-1:0]           first_c;
  logic [IW-1:0]              enc;
  logic                       ins_ok;
  logic                       del_ok;
  logic [olist_pkg::STATUS_W-1:0] status_c;

  assign is_ins  = (op == olist_pkg::OP_INSERT);
  assign is_find = (op == olist_pkg::OP_DELETE) || (op == olist_pkg::OP_SEARCH);

  assign commit = (state == S_APPLY) && (!rsp.valid || rsp.ready);
  assign req.ready = (state == S_IDLE) || commit;
  assign accept = req.valid && req.ready;

  // Insert point: the requested position, or the tail when it lies beyond.
  assign pivot = (CW'(pos) >= CW'(fill)) ? fill : FW'(pos);

  for (genvar i = 0; i < DEPTH; i++) begin : g_mark
    assign mark_c[i] = is_ins ? (FW'(i) >= pivot) : seen[i];
    if (i == 0) begin : g_head
      assign first_c[i] = mark_c[i];
      assign first[i]   = mark[i];
    end else begin : g_body
      assign first_c[i] = mark_c[i] & ~mark_c[i-1];
      assign first[i]   = mark[i] & ~mark[i-1];
    end
  end

  always_comb begin
    enc = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first_c[i]) begin
        enc = enc | IW'(i);
      end
    end
  end

  assign ins_ok = is_ins && !full;
  assign del_ok = (op == olist_pkg::OP_DELETE) && found;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cmd
    assign cmd[i].live      = (FW'(i) < fill);
    assign cmd[i].take_word = commit && ins_ok && first[i];
    assign cmd[i].take_prev = commit && ins_ok && mark[i] && !first[i];
    assign cmd[i].take_next = commit && del_ok && mark[i];
  end

  always_comb begin
    fill_next = fill;
    if (ins_ok) begin
      fill_next = fill + FW'(1);
    end else if (del_ok) begin
      fill_next = fill - FW'(1);
    end
  end

  always_comb begin
    status_c = olist_pkg::ST_DONE;
    if (is_ins && full) begin
      status_c = olist_pkg::ST_FULL;
    end else if (is_find && !found) begin
      status_c = olist_pkg::ST_NOTFOUND;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_MATCH;
      end
      S_MATCH: begin
        state_next = S_APPLY;
      end
      S_APPLY: begin
        if (commit) state_next = accept ? S_MATCH : S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        fill      <= fill_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op  <= req.op;
      key <= req.value;
      pos <= req.position;
    end
    if (state == S_MATCH) begin
      mark    <= mark_c;
      hit_pos <= is_ins ? CW'(pivot) : CW'(enc);
      found   <= is_find && seen[DEPTH-1];
      full    <= (fill == FW'(DEPTH));
    end
    if (commit) begin
      rsp.status <= status_c;
      rsp.found  <= found;
      rsp.where  <= (ins_ok || (is_find && found)) ?
                    olist_pkg::WHERE_W'(hit_pos) : '0;
      rsp.length <= olist_pkg::LENGTH_W'(CW'(fill_next));
    end
  end

endmodule

// ===== design/ordered_list_engine.sv =====
// ----------------------------------------------------------------------------
// ordered_list_engine: ordered list of signed words kept in a row of cells
// Insert at a position, delete the first match, or search for a word.
// ----------------------------------------------------------------------------
// The block takes one request word on the req channel (op, value, position)
// and returns one response word on the rsp channel (status, found, where,
// length) for every request. Both channels use a valid/ready handshake.
//
// A word accepted at a clock edge goes through the match state and then the
// apply state. In the match state every cell compares its entry with the
// key and a first-match prefix ripples down the row of cells; the marks are
// registered. In the apply state the cells load their neighbor's entry (or
// the key) to open or close a gap, and the response register is loaded. A
// new request is taken at that same edge, so the block overlaps the next
// request word with the response of the last one.
//
// The response sits in an output register. If the receiver stalls, the
// block still accepts one more request and works it through the match
// cycle, then holds it until the response register is free.
//
// Reset clears the length to zero and drops any pending response; the
// entries themselves are not cleared, since only cells below the length
// are ever compared or reported.
// ----------------------------------------------------------------------------
module ordered_list_engine #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  olist_req_if.sink   req,
  olist_rsp_if.source rsp
);

  logic [DATA_WIDTH-1:0]  key;
  logic [DEPTH-1:0]       seen;
  olist_pkg::cell_cmd_t   cmd [DEPTH];
  logic [DATA_WIDTH-1:0]  data [DEPTH];

  olist_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .seen (seen),
    .key  (key),
    .cmd  (cmd)
  );

  // Cell 0 is the head. Each cell sees its neighbors' entries; the head has
  // no predecessor and the tail cell never shifts in from beyond the end,
  // so those ends are tied to the key and to the cell's own entry.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_data;
    logic [DATA_WIDTH-1:0] next_data;
    logic                  seen_in;

    if (i == 0) begin : g_head
      assign prev_data = key;
      assign seen_in   = 1'b0;
    end else begin : g_body
      assign prev_data = data[i-1];
      assign seen_in   = seen[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_data = data[i];
    end else begin : g_inner
      assign next_data = data[i+1];
    end

    olist_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd[i]),
      .key       (key),
      .prev_data (prev_data),
      .next_data (next_data),
      .seen_in   (seen_in),
      .seen_out  (seen[i]),
      .data      (data[i])
    );
  end

endmodule

// ===== design/olist_checker.sv =====
// ----------------------------------------------------------------------------
// olist_checker: port checks of the ordered list engine
// Watches the response channel for held words and consistent status codes.
// ----------------------------------------------------------------------------
module olist_checker #(
  parameter int DEPTH = 16
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            rsp_valid,
  input logic                            rsp_ready,
  input logic [olist_pkg::STATUS_W-1:0]  rsp_status,
  input logic                            rsp_found,
  input logic [olist_pkg::WHERE_W-1:0]   rsp_where,
  input logic [olist_pkg::LENGTH_W-1:0]  rsp_length
);

  // A stalled response word stays offered.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response word dropped while stalled");

  // A rejected insert reports a full list and nothing else.
  a_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == olist_pkg::ST_FULL) |->
      !rsp_found && (rsp_where == '0) &&
      (rsp_length == olist_pkg::LENGTH_W'(DEPTH)))
    else $error("full status with inconsistent fields");

  // A miss reports no position.
  a_miss: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == olist_pkg::ST_NOTFOUND) |->
      !rsp_found && (rsp_where == '0))
    else $error("not-found status with a position or found flag");

  // Found is only raised with a done status.
  a_found: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_found |-> (rsp_status == olist_pkg::ST_DONE))
    else $error("found flag with an error status");

endmodule

bind ordered_list_engine olist_checker #(
  .DEPTH (DEPTH)
) u_olist_checker (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.status),
  .rsp_found  (rsp.found),
  .rsp_where  (rsp.where),
  .rsp_length (rsp.length)
);
